@@ rtl/pid_servo_angle_regulator_core_defines.svh @@
// Assertion macros shared by the servo regulator RTL.
`ifndef PID_SERVO_ANGLE_REGULATOR_CORE_DEFINES_SVH
`define PID_SERVO_ANGLE_REGULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define PSAR_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check a consequence in the cycle after its trigger
`define PSAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSAR_ASSERT_HOLDS(lbl, cond, msg)
`define PSAR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/psar_pkg.sv @@
// Types, constants and helper functions of the servo angle regulator.
package psar_pkg;

  // Fixed field widths
  localparam int GAIN_W      = 16;
  localparam int ANGLE_OUT_W = 16;
  localparam int DUTY_OUT_W  = 12;
  localparam int CMP_W       = 13;
  localparam int INTEG_W     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Fixed-point constants
  localparam int FRAC_BITS     = 8;
  localparam int TRUNC_BIAS    = (1 << FRAC_BITS) - 1;
  localparam int ANGLE_STEP    = 45;
  localparam int ANGLE_OFFSET  = 23040;
  localparam int INTEG_LIMIT   = 2560;
  localparam int PULSE_BASE    = 3000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN_P = 2'd1,
    REG_GAIN_I = 2'd2,
    REG_GAIN_D = 2'd3
  } cfg_reg_t;

  // Signed width that holds the converted angle for a given sample width
  function automatic int angle_width(input int sample_bits);
    return (sample_bits + 7 > ANGLE_OUT_W) ? sample_bits + 7 : ANGLE_OUT_W;
  endfunction

endpackage

@@ rtl/psar_if.sv @@
// Stream interfaces for sample words in and duty words out.
interface psar_in_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface psar_out_if import psar_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [DUTY_OUT_W-1:0]  drive_duty;
  logic        [CMP_W-1:0]       compare_count;
  logic signed [ANGLE_OUT_W-1:0] measured_angle;

  modport source (output valid, output drive_duty, output compare_count,
                  output measured_angle, input ready);
  modport sink   (input valid, input drive_duty, input compare_count,
                  input measured_angle, output ready);
endinterface

@@ rtl/psar_error.sv @@
// Sample to angle conversion, error, clamped integral and error difference.
module psar_error import psar_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic        [SAMPLE_BITS-1:0]                    sample,
  input  logic signed [GAIN_W-1:0]                         target,
  input  logic signed [INTEG_W-1:0]                        integ_q,
  input  logic signed [angle_width(SAMPLE_BITS):0]         err_q,
  output logic signed [angle_width(SAMPLE_BITS)-1:0]       angle,
  output logic signed [angle_width(SAMPLE_BITS):0]         err,
  output logic signed [INTEG_W-1:0]                        integ_nxt,
  output logic signed [angle_width(SAMPLE_BITS)+1:0]       derr
);

  localparam int ANG_W  = angle_width(SAMPLE_BITS);
  localparam int ERR_W  = ANG_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int IS_W   = ERR_W + 1;

  localparam logic signed [IS_W-1:0] LIM_HI = IS_W'(INTEG_LIMIT);
  localparam logic signed [IS_W-1:0] LIM_LO = -LIM_HI;

  logic signed [IS_W-1:0] isum;

  // Convert the raw reading to Q8 degrees
  assign angle = ANG_W'(signed'({1'b0, sample}) * ANGLE_STEP) - ANG_W'(ANGLE_OFFSET);

  // Form the error and its change since the last word
  assign err  = ERR_W'(target) - ERR_W'(angle);
  assign derr = DIFF_W'(err) - DIFF_W'(err_q);

  // Add to the integral and clamp to the limit
  assign isum = IS_W'(integ_q) + IS_W'(err);

  always_comb begin
    priority if (isum > LIM_HI) begin
      integ_nxt = INTEG_W'(LIM_HI);
    end else if (isum < LIM_LO) begin
      integ_nxt = INTEG_W'(LIM_LO);
    end else begin
      integ_nxt = INTEG_W'(isum);
    end
  end

endmodule

@@ rtl/psar_duty.sv @@
// Term sum, truncation toward zero and saturating duty accumulation.
module psar_duty import psar_pkg::*; #(
  parameter int TERM_W = 26,
  parameter int ACC_W  = 12,
  parameter int DUTY_SPAN = 3000
) (
  input  logic signed [TERM_W-1:0] p_term,
  input  logic signed [TERM_W-1:0] i_term,
  input  logic signed [TERM_W-1:0] d_term,
  input  logic        [ACC_W-1:0]  acc_q,
  output logic        [ACC_W-1:0]  duty_nxt
);

  localparam int SUM_W = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] SPAN_S = SUM_W'(DUTY_SPAN);
  localparam logic signed [SUM_W-1:0] ZERO_S = '0;

  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] whole;
  logic signed [SUM_W-1:0] dsum;

  // Sum the three Q8 terms
  assign total = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

  // Drop the fraction, rounding toward zero
  assign whole = (total + ((total < ZERO_S) ? SUM_W'(TRUNC_BIAS) : ZERO_S)) >>> FRAC_BITS;

  // Advance the duty value and saturate
  assign dsum = signed'(SUM_W'(acc_q)) + whole;

  always_comb begin
    priority if (dsum < ZERO_S) begin
      duty_nxt = '0;
    end else if (dsum > SPAN_S) begin
      duty_nxt = ACC_W'(SPAN_S);
    end else begin
      duty_nxt = ACC_W'(dsum);
    end
  end

endmodule

@@ rtl/pid_servo_angle_regulator_core.sv @@
// Top level of the PID servo angle regulator with clamped integral.
// Takes one position sample word per clock and returns one duty word per sample:
// the saturated duty (0..DUTY_SPAN), the servo compare count (3000 plus duty) and
// the measured angle in Q8 degrees. A word sits in the input register, and the
// angle, error, clamped integral, the three gain products, the term sum and the
// duty saturation are all worked out combinationally from there into the result
// register, which loads it once that register is empty or being read. A new sample is
// taken every clock while the output side keeps up. The input register holds only
// while it is full and the result register is full and not taken, so at most two
// words are in flight. The user must write gains and the setpoint through the cfg
// port only while no word is in flight (not enforced); control registers reset to zero.
`include "pid_servo_angle_regulator_core_defines.svh"

module pid_servo_angle_regulator_core import psar_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int DUTY_SPAN   = 3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psar_in_if.sink               in_ch,
  psar_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ANG_W  = angle_width(SAMPLE_BITS);
  localparam int ERR_W  = ANG_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + INTEG_W;
  localparam int D_W    = GAIN_W + DIFF_W;
  localparam int TERM_W = D_W - FRAC_BITS;
  localparam int ACC_W  = $clog2(DUTY_SPAN + 1);

  localparam logic signed [INTEG_W-1:0] INTEG_HI = INTEG_W'(INTEG_LIMIT);
  localparam logic signed [INTEG_W-1:0] INTEG_LO = -INTEG_HI;

  // Configuration registers
  logic signed [GAIN_W-1:0] target_r;
  logic signed [GAIN_W-1:0] gain_p_r;
  logic signed [GAIN_W-1:0] gain_i_r;
  logic signed [GAIN_W-1:0] gain_d_r;

  // Register valids and enables
  logic v_a_r;
  logic out_valid_r;
  logic en_a;
  logic en_d;
  logic take_word;

  // Input register
  logic [SAMPLE_BITS-1:0] sample_r;

  // Error state
  logic signed [ANG_W-1:0]   angle_nxt;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [DIFF_W-1:0]  derr_nxt;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r;

  // Gain products
  logic signed [P_W-1:0]     p_full;
  logic signed [I_W-1:0]     i_full;
  logic signed [D_W-1:0]     d_full;
  logic signed [TERM_W-1:0]  p_term;
  logic signed [TERM_W-1:0]  i_term;
  logic signed [TERM_W-1:0]  d_term;

  // Result register
  logic [ACC_W-1:0]          duty_acc_r;
  logic [ACC_W-1:0]          duty_nxt;
  logic [CMP_W-1:0]          cmp_r;
  logic signed [ANGLE_OUT_W-1:0] angle_d_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET: target_r <= signed'(cfg_wdata);
        REG_GAIN_P: gain_p_r <= signed'(cfg_wdata);
        REG_GAIN_I: gain_i_r <= signed'(cfg_wdata);
        REG_GAIN_D: gain_d_r <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance each register when it is empty or the next one moves
  assign en_d = !out_valid_r || out_ch.ready;
  assign en_a = !v_a_r || en_d;
  assign in_ch.ready = en_a;
  assign take_word = en_d && v_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) v_a_r       <= in_ch.valid;
      if (en_d) out_valid_r <= v_a_r;
    end
  end

  // Capture the sample word
  always_ff @(posedge clk) begin
    if (en_a && in_ch.valid) begin
      sample_r <= in_ch.adc_sample;
    end
  end

  psar_error #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_error (
    .sample    (sample_r),
    .target    (target_r),
    .integ_q   (integ_r),
    .err_q     (err_r),
    .angle     (angle_nxt),
    .err       (err_nxt),
    .integ_nxt (integ_nxt),
    .derr      (derr_nxt)
  );

  // Multiply by the Q8.8 gains and drop the fraction bits
  assign p_full = P_W'(gain_p_r) * P_W'(err_nxt);
  assign i_full = I_W'(gain_i_r) * I_W'(integ_nxt);
  assign d_full = D_W'(gain_d_r) * D_W'(derr_nxt);

  assign p_term = TERM_W'(p_full >>> FRAC_BITS);
  assign i_term = TERM_W'(i_full >>> FRAC_BITS);
  assign d_term = TERM_W'(d_full >>> FRAC_BITS);

  psar_duty #(
    .TERM_W    (TERM_W),
    .ACC_W     (ACC_W),
    .DUTY_SPAN (DUTY_SPAN)
  ) u_duty (
    .p_term   (p_term),
    .i_term   (i_term),
    .d_term   (d_term),
    .acc_q    (duty_acc_r),
    .duty_nxt (duty_nxt)
  );

  // Update integral, previous error and duty with each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r      <= '0;
      integ_r    <= '0;
      duty_acc_r <= '0;
    end else if (take_word) begin
      err_r      <= err_nxt;
      integ_r    <= integ_nxt;
      duty_acc_r <= duty_nxt;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (take_word) begin
      cmp_r     <= CMP_W'(int'(duty_nxt) + PULSE_BASE);
      angle_d_r <= ANGLE_OUT_W'(angle_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive_duty     = DUTY_OUT_W'(duty_acc_r);
  assign out_ch.compare_count  = cmp_r;
  assign out_ch.measured_angle = angle_d_r;

  // Checks
  `PSAR_ASSERT_HOLDS(a_duty_range, duty_acc_r <= ACC_W'(DUTY_SPAN), "duty beyond span")
  `PSAR_ASSERT_HOLDS(a_integ_range, (integ_r <= INTEG_HI) && (integ_r >= INTEG_LO), "clamp")
  `PSAR_ASSERT_NEXT(a_state_hold, !take_word, $stable(integ_r) && $stable(err_r), "state moved")
  `PSAR_ASSERT_NEXT(a_out_fill, take_word, out_valid_r, "result word lost on its way out")

endmodule

@@ test/tb_pid_servo_angle_regulator_core.sv @@
// Self-checking testbench for the PID servo angle regulator core.
module tb_pid_servo_angle_regulator_core;
  import psar_pkg::*;

  localparam int SAMPLE_W    = 10;
  localparam int DUTY_MAX    = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int FILL_ITEMS  = 60;
  localparam int DRAIN_WAIT  = 8;
  localparam int PRESS_PHASE = 4;

  typedef struct packed {
    logic        [DUTY_OUT_W-1:0]  duty;
    logic        [CMP_W-1:0]       cmp;
    logic signed [ANGLE_OUT_W-1:0] angle;
  } duty_word_t;

  // Track regulator state and hold the duty words still to come
  class servo_scoreboard;
    longint     target_q8, kp, ki, kd;
    longint     integ, prev_err, duty_acc;
    int         errors;
    duty_word_t expected_q[$];

    function new();
      target_q8 = 0; kp = 0; ki = 0; kd = 0;
      integ = 0; prev_err = 0; duty_acc = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      longint sval;
      sval = longint'($signed(val));
      case (idx)
        REG_TARGET: target_q8 = sval;
        REG_GAIN_P: kp = sval;
        REG_GAIN_I: ki = sval;
        REG_GAIN_D: kd = sval;
        default: ;
      endcase
    endfunction

    // Compute the duty word that an accepted sample produces
    function void note_sample(logic [SAMPLE_W-1:0] s);
      longint     angle, err, p_t, i_t, d_t, whole;
      duty_word_t w;
      angle = ANGLE_STEP * longint'(s) - ANGLE_OFFSET;
      err   = target_q8 - angle;
      integ = integ + err;
      if (integ > INTEG_LIMIT) integ = INTEG_LIMIT;
      else if (integ < -INTEG_LIMIT) integ = -INTEG_LIMIT;
      p_t = (kp * err) >>> FRAC_BITS;
      i_t = (ki * integ) >>> FRAC_BITS;
      d_t = (kd * (err - prev_err)) >>> FRAC_BITS;
      prev_err = err;
      // Integer division truncates toward zero
      whole = (p_t + i_t + d_t) / (longint'(1) << FRAC_BITS);
      duty_acc = duty_acc + whole;
      if (duty_acc < 0) duty_acc = 0;
      else if (duty_acc > DUTY_MAX) duty_acc = DUTY_MAX;
      w.duty  = duty_acc[DUTY_OUT_W-1:0];
      w.cmp   = CMP_W'(PULSE_BASE + duty_acc);
      w.angle = angle[ANGLE_OUT_W-1:0];
      expected_q.push_back(w);
    endfunction

    // Compare a delivered duty word with the oldest expectation
    function void check_word(logic [DUTY_OUT_W-1:0] duty, logic [CMP_W-1:0] cmp,
                             logic signed [ANGLE_OUT_W-1:0] angle);
      duty_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: duty %0d cmp %0d angle %0d",
                 $time, duty, cmp, angle);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (duty !== w.duty) begin
        $display("%0t: drive_duty expected %0d actual %0d", $time, w.duty, duty);
        errors++;
      end
      if (cmp !== w.cmp) begin
        $display("%0t: compare_count expected %0d actual %0d", $time, w.cmp, cmp);
        errors++;
      end
      if (angle !== w.angle) begin
        $display("%0t: measured_angle expected %0d actual %0d", $time, w.angle, angle);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  hold_req = 1'b0;
  int                    center_sample;

  servo_scoreboard sb = new();

  psar_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  psar_out_if out_ch ();

  pid_servo_angle_regulator_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .DUTY_SPAN  (DUTY_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Receive duty words; stall in random segments, once for a long stretch
  int  seg_left = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.drive_duty, out_ch.compare_count, out_ch.measured_angle);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (seg_left == 0) begin
      seg_left  = $urandom_range(5, 60);
      stall_pct = 25 * $urandom_range(0, 3);
    end
    seg_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // End the run when no word moves on either side for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Program all four registers and aim the tracking samples at the setpoint
  task automatic program_regs(input logic [CFG_DATA_W-1:0] tgt, gp, gi, gd);
    int c;
    write_cfg(REG_TARGET, tgt);
    write_cfg(REG_GAIN_P, gp);
    write_cfg(REG_GAIN_I, gi);
    write_cfg(REG_GAIN_D, gd);
    cfg_we <= 1'b0;
    c = (int'($signed(tgt)) + ANGLE_OFFSET) / ANGLE_STEP;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    center_sample = c;
  endtask

  // Offer one sample word and hold it until the block takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly samples near the setpoint so the integral leaves its clamp
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int center);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 8)
      v = $urandom_range(0, 1) ? 1023 : 0;
    else if (r < 60)
      v = center + int'($urandom_range(0, 24)) - 12;
    else
      v = $urandom_range(0, 1023);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  logic [SAMPLE_W-1:0]   directed_samples[$] = '{
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd512, 10'd512, 10'd511, 10'h155, 10'h2AA, 10'd1, 10'd1022,
    10'd0, 10'd1023, 10'd513, 10'd512
  };
  logic [CFG_DATA_W-1:0] tgt, gp, gi, gd;
  int                    burst_left, gap;

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_TARGET;
    cfg_wdata        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clamp the integral both ways and saturate the duty
    program_regs(16'd0, 16'd4096, 16'd256, 16'd512);
    foreach (directed_samples[k]) send_sample(directed_samples[k]);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          tgt = 16'h7FFF; gp = 16'h7FFF; gi = 16'h7FFF; gd = 16'h7FFF;
        end
        1: begin
          tgt = 16'h8000; gp = 16'h8000; gi = 16'h8000; gd = 16'h8000;
        end
        2: begin
          tgt = 16'(23040); gp = '0; gi = '0; gd = '0;
        end
        3: begin
          tgt = 16'(-23040); gp = 16'd128; gi = 16'(-16); gd = 16'd512;
        end
        4, 5: begin
          tgt = 16'(int'($urandom_range(0, 46080)) - 23040);
          gp  = 16'(int'($urandom_range(0, 1024)) - 512);
          gi  = 16'(int'($urandom_range(0, 1024)) - 512);
          gd  = 16'(int'($urandom_range(0, 1024)) - 512);
        end
        6: begin
          tgt = 16'($urandom); gp = 16'($urandom); gi = 16'($urandom); gd = 16'($urandom);
        end
        default: begin
          tgt = 16'($urandom);
          gp  = 16'(int'($urandom_range(0, 4096)) - 2048);
          gi  = 16'(int'($urandom_range(0, 4096)) - 2048);
          gd  = 16'(int'($urandom_range(0, 4096)) - 2048);
        end
      endcase
      program_regs(tgt, gp, gi, gd);
      if (ph == PRESS_PHASE) hold_req = 1'b1;
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Keep offering words back to back while the receiver holds off
        if (burst_left == 0 && !(ph == PRESS_PHASE && k < FILL_ITEMS)) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        send_sample(pick_sample(center_sample));
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/psar_pkg.sv
rtl/psar_if.sv
rtl/psar_error.sv
rtl/psar_duty.sv
rtl/pid_servo_angle_regulator_core.sv
test/tb_pid_servo_angle_regulator_core.sv
